// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// clocked assertion helpers shared by the rtl files
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising edge outside reset
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
    `ASSERT_CLK(lbl, clk, rstn, !(expr), msg)

`endif

// ===== src/lsh_pkg.sv =====
// ----------------------------------------------------------------------------
// lsh_pkg
// shared types and constants of the 3x3 laplacian sharpening filter
// ----------------------------------------------------------------------------
package lsh_pkg;

    // field widths
    localparam int PIX_W   = 8;
    localparam int WID_W   = 11;
    localparam int HGT_W   = 13;
    localparam int CHN_W   = 3;
    localparam int ROW_W   = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    // register reset values and limits
    localparam logic [WID_W-1:0] WIDTH_RESET   = 11'd640;
    localparam logic [HGT_W-1:0] HEIGHT_RESET  = 13'd480;
    localparam logic [CHN_W-1:0] CHAN_RESET    = 3'd3;
    localparam logic [HGT_W-1:0] HEIGHT_MIN    = 13'd3;
    localparam logic [HGT_W-1:0] HEIGHT_MAX    = 13'd4096;
    localparam logic [WID_W-1:0] WIDTH_MIN     = 11'd3;

    // stencil gain on the center byte
    localparam int CENTER_GAIN = 5;

    // output queue geometry
    localparam int OQ_DEPTH = 4;
    localparam int OQ_PTR_W = 2;
    localparam int OQ_LVL_W = 3;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH_PIXELS  = 2'd0,
        CFG_HEIGHT_ROWS   = 2'd1,
        CFG_CHANNEL_COUNT = 2'd2
    } cfg_reg_t;

    // one result item
    typedef struct packed {
        logic             frame_end;
        logic             row_end;
        logic [PIX_W-1:0] sharp_byte;
    } lsh_result_t;

endpackage

// ===== src/lsh_out_fifo.sv =====
// ----------------------------------------------------------------------------
// lsh_out_fifo
// small register queue that decouples the filter pipeline from the consumer
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lsh_out_fifo
    import lsh_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  lsh_result_t         push_item,
    input  logic                pop_ready,
    output logic                out_valid,
    output lsh_result_t         out_item,
    output logic [OQ_LVL_W-1:0] level
);

    lsh_result_t           slot_reg [OQ_DEPTH];
    logic [OQ_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [OQ_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [OQ_LVL_W-1:0]   level_reg, level_next;
    logic                  pop;

    assign out_valid = (level_reg != '0);
    assign out_item  = slot_reg[rd_ptr_reg];
    assign pop       = out_valid && pop_ready;
    assign level     = level_reg;

    // pointer and level update
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        level_next  = level_reg;
        if (push && !pop) begin
            level_next = level_reg + 1'b1;
        end else if (pop && !push) begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    // payload slots
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    `ASSERT_NEVER(a_oq_overflow, aclk, aresetn, push && !pop && (level_reg == OQ_LVL_W'(OQ_DEPTH)), "output queue overflow")
    `ASSERT_CLK(a_oq_level_step, aclk, aresetn, (push && !pop) |=> (level_reg == $past(level_reg) + 1'b1), "output queue level did not advance")

endmodule

// ===== src/laplacian_sharpen_3x3.sv =====
// each result passes from the stage 1 registers into the output queue before it can transfer
// throughput: one byte per clock while the queue has room; each line store has one read and one write port,
// and the right neighbour read is issued ahead and reused as center and left later
// a 4-entry output queue lets input continue while results wait on the consumer
// reset: counters to 0 and size registers to 640 x 480 x 3; line stores are not
// cleared and need no clearing pass, every entry is written before it is used
// ----------------------------------------------------------------------------
// laplacian_sharpen_3x3
// streaming 3x3 sharpening filter (5*center minus four neighbours) over
// channel-interleaved bytes, emitting output row r-1 while input row r arrives
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module laplacian_sharpen_3x3
    import lsh_pkg::*;
#(
    parameter int MAX_WIDTH    = 1024,
    parameter int MAX_CHANNELS = 4
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [PIX_W-1:0]      s_tdata,   // [7:0] pixel_byte
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [PIX_W-1:0]      m_tdata,   // [7:0] sharp_byte
    output logic                  m_tlast,   // row_end
    output logic                  m_tuser    // [0] frame_end
);

    localparam int LINE_DEPTH = MAX_WIDTH * MAX_CHANNELS;
    localparam int COL_W      = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int RB_W       = COL_W + 1;
    localparam int EW_W       = $clog2(MAX_WIDTH + 1);
    localparam int CH_W       = $clog2(MAX_CHANNELS + 1);
    localparam int HIST_LEN   = 2 * MAX_CHANNELS;

    // configuration registers
    logic [WID_W-1:0] width_reg;
    logic [HGT_W-1:0] height_reg;
    logic [CHN_W-1:0] chan_reg;

    // effective geometry
    logic [EW_W-1:0]  eff_w;
    logic [CH_W-1:0]  eff_ch;
    logic [HGT_W-1:0] eff_h;
    logic [RB_W-1:0]  row_bytes;

    // position counters
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;

    // stage 0 decode
    logic             in_xfer;
    logic [RB_W-1:0]  col_plus_ch;
    logic [RB_W-1:0]  col_plus_one;
    logic [COL_W-1:0] ahead_addr;
    logic             last_col;
    logic             last_row;
    logic             interior;

    // line stores
    logic [PIX_W-1:0] line_above_mem  [LINE_DEPTH];
    logic [PIX_W-1:0] line_center_mem [LINE_DEPTH];
    logic [PIX_W-1:0] above_rd_reg;
    logic [PIX_W-1:0] ahead_rd_reg;

    // stage 1
    logic             s1_valid_reg;
    logic             s1_emit_reg;
    logic             s1_interior_reg;
    logic             s1_last_col_reg;
    logic             s1_last_row_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic [PIX_W-1:0] s1_down_reg;
    logic [PIX_W-1:0] hist_reg [HIST_LEN];
    logic [PIX_W-1:0] center;
    logic [PIX_W-1:0] left;
    logic [PIX_W+1:0] ring_sum;
    logic [PIX_W+2:0] gain_center;
    logic signed [PIX_W+3:0] stencil;
    lsh_result_t      result;

    // output queue
    logic [OQ_LVL_W-1:0] oq_level;
    logic                oq_valid;
    lsh_result_t         oq_item;

    // ------------------------------------------------------------------
    // configuration port
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            chan_reg   <= CHAN_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_reg_t'(cfg_index))
                CFG_WIDTH_PIXELS:  width_reg  <= cfg_data[WID_W-1:0];
                CFG_HEIGHT_ROWS:   height_reg <= cfg_data[HGT_W-1:0];
                CFG_CHANNEL_COUNT: chan_reg   <= cfg_data[CHN_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp sizes into the supported range
    always_comb begin
        if (width_reg < WIDTH_MIN) begin
            eff_w = EW_W'(3);
        end else if (32'(width_reg) > MAX_WIDTH) begin
            eff_w = EW_W'(MAX_WIDTH);
        end else begin
            eff_w = EW_W'(width_reg);
        end

        if (chan_reg == '0) begin
            eff_ch = CH_W'(1);
        end else if (32'(chan_reg) > MAX_CHANNELS) begin
            eff_ch = CH_W'(MAX_CHANNELS);
        end else begin
            eff_ch = CH_W'(chan_reg);
        end

        if (height_reg < HEIGHT_MIN) begin
            eff_h = HEIGHT_MIN;
        end else if (height_reg > HEIGHT_MAX) begin
            eff_h = HEIGHT_MAX;
        end else begin
            eff_h = height_reg;
        end
    end

    assign row_bytes = RB_W'(RB_W'(eff_w) * RB_W'(eff_ch));

    // ------------------------------------------------------------------
    // stage 0: position decode and line store reads
    assign in_xfer      = s_tvalid && s_tready;
    assign col_plus_ch  = {1'b0, col_reg} + RB_W'(eff_ch);
    assign col_plus_one = {1'b0, col_reg} + RB_W'(1);
    assign last_col     = (col_plus_one >= row_bytes);
    assign last_row     = (({1'b0, row_reg} + HGT_W'(1)) >= eff_h);
    assign interior     = (row_reg >= ROW_W'(2))
                       && ({1'b0, col_reg} >= RB_W'(eff_ch))
                       && (col_plus_ch < row_bytes);

    // read one pixel ahead; past the row end it wraps to the next row's start
    assign ahead_addr = (col_plus_ch < row_bytes) ? col_plus_ch[COL_W-1:0]
                                                  : COL_W'(col_plus_ch - row_bytes);

    // counter next values
    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (in_xfer) begin
            if (last_col) begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + 1'b1;
            end else begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // line store read ports, registered on each accepted byte
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            above_rd_reg <= line_above_mem[col_reg];
            ahead_rd_reg <= line_center_mem[ahead_addr];
        end
    end

    // stage 1 control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= in_xfer;
        end
    end

    // stage 1 payload
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            s1_emit_reg     <= (row_reg != '0);
            s1_interior_reg <= interior;
            s1_last_col_reg <= last_col;
            s1_last_row_reg <= last_row;
            s1_col_reg      <= col_reg;
            s1_down_reg     <= s_tdata;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: history of ahead reads gives center and left
    always_ff @(posedge aclk) begin
        if (s1_valid_reg) begin
            hist_reg[0] <= ahead_rd_reg;
            for (int i = 1; i < HIST_LEN; i++) begin
                hist_reg[i] <= hist_reg[i-1];
            end
        end
    end

    // tap select by channel count
    always_comb begin
        center = hist_reg[0];
        left   = hist_reg[1];
        for (int i = 0; i < MAX_CHANNELS; i++) begin
            if (eff_ch == CH_W'(i + 1)) begin
                center = hist_reg[i];
                left   = hist_reg[2*i+1];
            end
        end
    end

    // write back: old center moves up, new byte becomes center
    always_ff @(posedge aclk) begin
        if (s1_valid_reg) begin
            line_above_mem[s1_col_reg]  <= center;
            line_center_mem[s1_col_reg] <= s1_down_reg;
        end
    end

    // stencil and saturation
    always_comb begin
        ring_sum    = {2'b00, left} + {2'b00, ahead_rd_reg}
                    + {2'b00, above_rd_reg} + {2'b00, s1_down_reg};
        gain_center = (PIX_W+3)'(CENTER_GAIN) * {3'b000, center};
        stencil     = $signed({1'b0, gain_center}) - $signed({2'b00, ring_sum});

        result.row_end   = s1_last_col_reg;
        result.frame_end = s1_last_col_reg && s1_last_row_reg;
        if (!s1_interior_reg || (stencil < 0)) begin
            result.sharp_byte = '0;
        end else if (stencil > (PIX_W+4)'(255)) begin
            result.sharp_byte = '1;
        end else begin
            result.sharp_byte = stencil[PIX_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // output queue and input credit
    lsh_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s1_valid_reg && s1_emit_reg),
        .push_item (result),
        .pop_ready (m_tready),
        .out_valid (oq_valid),
        .out_item  (oq_item),
        .level     (oq_level)
    );

    // accept only while stage 1 and the queue together leave a free slot
    assign s_tready = (({{(OQ_LVL_W-1){1'b0}}, s1_valid_reg} + oq_level)
                       < OQ_LVL_W'(OQ_DEPTH));

    assign m_tvalid = oq_valid;
    assign m_tdata  = oq_item.sharp_byte;
    assign m_tlast  = oq_item.row_end;
    assign m_tuser  = oq_item.frame_end;

    `ASSERT_CLK(a_col_wrap, aclk, aresetn, (in_xfer && last_col) |=> (col_reg == '0), "column counter did not wrap at row end")
    `ASSERT_CLK(a_s1_follows, aclk, aresetn, in_xfer |=> s1_valid_reg, "accepted byte missing from stage 1")
    `ASSERT_CLK(a_frame_end_last, aclk, aresetn, (m_tvalid && m_tuser) |-> m_tlast, "frame end without row end")

endmodule
